[rtl/usvg_pkg.sv]
// Shared constants, register codes and the arctangent table for the UV sphere generator.
`default_nettype none
package usvg_pkg;

   localparam int CORDIC_STEPS_DEFAULT    = 16;
   localparam int COORD_FRAC_BITS_DEFAULT = 8;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_STACK_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLICE_COUNT  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS       = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_ROW_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_ROW_Y = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MATRIX_ROW_Z = 3'd5;

   localparam int ANG_W    = 32;
   localparam int CORDIC_W = 34;
   localparam int LOC_W    = 26;
   localparam int MUL_A_W  = 36;
   localparam int MUL_B_W  = 26;
   localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
   localparam int DIV_W    = 41;
   localparam int DIVISOR_W = 8;
   localparam int ACC_W    = 48;
   localparam int POS_W    = 21;

   localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = 34'sd652032874;

   function automatic logic [ANG_W-1:0] atan_turn(input logic [4:0] k);
      logic [ANG_W-1:0] v;
      case (k)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[rtl/usvg_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module usvg_div (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic [usvg_pkg::DIV_W-1:0]           dividend,
   input  wire logic [usvg_pkg::DIVISOR_W-1:0]       divisor,
   output logic                                      done,
   output logic [usvg_pkg::DIV_W-1:0]                quotient
);
   localparam int CW = $clog2(usvg_pkg::DIV_W);

   logic                                busy_ff;
   logic                                done_ff;
   logic [CW-1:0]                       cnt_ff;
   logic [usvg_pkg::DIV_W-1:0]          num_ff;
   logic [usvg_pkg::DIV_W-1:0]          quo_ff;
   logic [usvg_pkg::DIVISOR_W-1:0]      den_ff;
   logic [usvg_pkg::DIVISOR_W-1:0]      rem_ff;
   logic [usvg_pkg::DIVISOR_W:0]        rem_sh;
   logic                                fits;

   assign rem_sh = {rem_ff, num_ff[usvg_pkg::DIV_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= dividend;
            den_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= fits ? usvg_pkg::DIVISOR_W'(rem_sh - {1'b0, den_ff})
                           : rem_sh[usvg_pkg::DIVISOR_W-1:0];
            quo_ff <= {quo_ff[usvg_pkg::DIV_W-2:0], fits};
            num_ff <= {num_ff[usvg_pkg::DIV_W-2:0], 1'b0};
            cnt_ff <= CW'(cnt_ff + 1'b1);
            if (cnt_ff == CW'(usvg_pkg::DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule
`default_nettype wire

[rtl/usvg_mul.sv]
// Serial shift-add signed multiplier, one multiplier bit per cycle.
`default_nettype none
module usvg_mul (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [usvg_pkg::MUL_A_W-1:0]  a,
   input  wire logic signed [usvg_pkg::MUL_B_W-1:0]  b,
   output logic                                      done,
   output logic signed [usvg_pkg::MUL_P_W-1:0]       product
);
   localparam int CW = $clog2(usvg_pkg::MUL_B_W);

   logic                                busy_ff;
   logic                                done_ff;
   logic [CW-1:0]                       cnt_ff;
   logic signed [usvg_pkg::MUL_P_W-1:0] a_sh_ff;
   logic [usvg_pkg::MUL_B_W-1:0]        b_sh_ff;
   logic signed [usvg_pkg::MUL_P_W-1:0] acc_ff;
   logic signed [usvg_pkg::MUL_P_W-1:0] term;

   always_comb begin
      term = '0;
      if (b_sh_ff[0]) begin
         term = (cnt_ff == CW'(usvg_pkg::MUL_B_W - 1)) ? -a_sh_ff : a_sh_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_sh_ff <= usvg_pkg::MUL_P_W'(a);
            b_sh_ff <= b;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            acc_ff  <= acc_ff + term;
            a_sh_ff <= a_sh_ff <<< 1;
            b_sh_ff <= b_sh_ff >> 1;
            cnt_ff  <= CW'(cnt_ff + 1'b1);
            if (cnt_ff == CW'(usvg_pkg::MUL_B_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;
endmodule
`default_nettype wire

[rtl/usvg_cordic.sv]
// Iterative rotation-mode CORDIC giving cosine and sine of a binary turn angle.
`default_nettype none
module usvg_cordic #(
   parameter int STEPS = usvg_pkg::CORDIC_STEPS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [usvg_pkg::ANG_W-1:0]            angle,
   output logic                                       done,
   output logic signed [usvg_pkg::CORDIC_W-1:0]       cos_out,
   output logic signed [usvg_pkg::CORDIC_W-1:0]       sin_out
);
   localparam int KW = $clog2(STEPS);
   localparam int W  = usvg_pkg::CORDIC_W;
   localparam logic signed [W-1:0] QUARTER = 34'sd1073741824;
   localparam logic signed [W-1:0] HALF    = 34'sd2147483648;

   logic                busy_ff;
   logic                done_ff;
   logic                flip_ff;
   logic [KW-1:0]       k_ff;
   logic signed [W-1:0] x_ff;
   logic signed [W-1:0] y_ff;
   logic signed [W-1:0] z_ff;
   logic signed [W-1:0] z0;
   logic signed [W-1:0] dx;
   logic signed [W-1:0] dy;
   logic signed [W-1:0] at;

   assign z0 = {{(W - usvg_pkg::ANG_W){angle[usvg_pkg::ANG_W-1]}}, angle};
   assign dx = y_ff >>> k_ff;
   assign dy = x_ff >>> k_ff;
   assign at = {{(W - usvg_pkg::ANG_W){1'b0}}, usvg_pkg::atan_turn(5'(k_ff))};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            k_ff    <= '0;
            x_ff    <= usvg_pkg::GAIN_Q30;
            y_ff    <= '0;
            if (z0 > QUARTER) begin
               z_ff    <= z0 - HALF;
               flip_ff <= 1'b1;
            end else if (z0 < -QUARTER) begin
               z_ff    <= z0 + HALF;
               flip_ff <= 1'b1;
            end else begin
               z_ff    <= z0;
               flip_ff <= 1'b0;
            end
         end else if (busy_ff) begin
            if (!z_ff[W-1]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + at;
            end
            k_ff <= KW'(k_ff + 1'b1);
            if (k_ff == KW'(STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign cos_out = flip_ff ? -x_ff : x_ff;
   assign sin_out = flip_ff ? -y_ff : y_ff;
endmodule
`default_nettype wire

[rtl/uv_sphere_vertex_generator.sv]
// Top level: vertex sequencer driving the serial divider, CORDIC and multiplier.
// A pole request skips the divider and CORDIC and runs nine products on the serial multiplier; a ring
// request first runs four quotients on the bit-serial divider, two CORDIC rotations and four
// scaling products on the multiplier, then the same nine matrix products.
// One request in flight; the next is accepted in the cycle after the result registers.
// Reset (synchronous): registers return to 8 stacks, 8 slices, radius 1.0, identity matrix.
`default_nettype none
module uv_sphere_vertex_generator #(
   parameter int CORDIC_STEPS    = usvg_pkg::CORDIC_STEPS_DEFAULT,
   parameter int COORD_FRAC_BITS = usvg_pkg::COORD_FRAC_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic                                 req_restart,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [usvg_pkg::POS_W-1:0]         rsp_pos_x,
   output logic signed [usvg_pkg::POS_W-1:0]         rsp_pos_y,
   output logic signed [usvg_pkg::POS_W-1:0]         rsp_pos_z,
   output logic [15:0]                               rsp_tex_u,
   output logic [15:0]                               rsp_tex_v,
   output logic [15:0]                               rsp_vertex_index,
   output logic                                      rsp_last_vertex,
   input  wire logic                                 csr_write_enable,
   input  wire logic [usvg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [usvg_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   localparam int LW = usvg_pkg::LOC_W;
   localparam int AW = usvg_pkg::ACC_W;
   localparam int SH = 24 - COORD_FRAC_BITS;
   localparam logic signed [AW-1:0] POS_MAX = 48'sd1048575;
   localparam logic signed [AW-1:0] POS_MIN = -48'sd1048576;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_SETUP = 4'd1;
   localparam logic [3:0] ST_DIV   = 4'd2;
   localparam logic [3:0] ST_DIVW  = 4'd3;
   localparam logic [3:0] ST_COR   = 4'd4;
   localparam logic [3:0] ST_CORW  = 4'd5;
   localparam logic [3:0] ST_SPH   = 4'd6;
   localparam logic [3:0] ST_SPHW  = 4'd7;
   localparam logic [3:0] ST_MAT   = 4'd8;
   localparam logic [3:0] ST_MATW  = 4'd9;
   localparam logic [3:0] ST_ROUND = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   logic [3:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic [8:0]  stack_count_ff;
   logic [7:0]  slice_count_ff;
   logic [15:0] radius_ff;
   logic [47:0] row_x_ff, row_y_ff, row_z_ff;

   logic [7:0]  ring_ff, col_ff;
   logic [15:0] vtx_ff;

   logic [7:0]  wring_ff, wcol_ff;
   logic [15:0] wvtx_ff;
   logic        wlast_ff;
   logic [15:0] tu_ff, tv_ff;
   logic [31:0] az_ff, el_ff;
   logic signed [usvg_pkg::CORDIC_W-1:0] ce_ff, se_ff, ca_ff, sa_ff;
   logic signed [LW-1:0] lx_ff, ly_ff, lz_ff, ringr_ff;
   logic signed [AW-1:0] acc_ff;
   logic signed [usvg_pkg::POS_W-1:0] pos_ff [3];
   logic [1:0]  idx_ff, row_ff, term_ff;

   logic signed [usvg_pkg::POS_W-1:0] rsp_pos_x_ff, rsp_pos_y_ff, rsp_pos_z_ff;
   logic [15:0] rsp_tex_u_ff, rsp_tex_v_ff, rsp_vertex_index_ff;
   logic        rsp_last_vertex_ff;

   logic [8:0]  stacks;
   logic [7:0]  last_ring, slices, col_eff;
   logic        out_free;

   logic                          div_start, div_done;
   logic [usvg_pkg::DIV_W-1:0]    div_num, div_quo;
   logic [usvg_pkg::DIVISOR_W-1:0] div_den;

   logic                          cor_start, cor_done;
   logic signed [usvg_pkg::CORDIC_W-1:0] cor_cos, cor_sin;

   logic                          mul_start, mul_done;
   logic signed [usvg_pkg::MUL_A_W-1:0] mul_a;
   logic signed [usvg_pkg::MUL_B_W-1:0] mul_b;
   logic signed [usvg_pkg::MUL_P_W-1:0] mul_p, mul_pr;

   logic [47:0]          row_word;
   logic signed [11:0]   coef;
   logic signed [LW-1:0] lsel;
   logic signed [AW-1:0] rnd, shifted;
   logic signed [usvg_pkg::POS_W-1:0] sat;

   assign stacks    = (stack_count_ff < 9'd3) ? 9'd3 :
                      (stack_count_ff > 9'd256) ? 9'd256 : stack_count_ff;
   assign last_ring = 8'(stacks - 9'd1);
   assign slices    = (slice_count_ff < 8'd3) ? 8'd3 : slice_count_ff;
   assign col_eff   = (col_ff > slices) ? slices : col_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (idx_ff)
         2'd0: begin
            div_num = ({33'd0, wring_ff} << 15) + {34'd0, last_ring[7:1]};
            div_den = last_ring;
         end
         2'd1: begin
            div_num = ({33'd0, wcol_ff} << 15) + {34'd0, slices[7:1]};
            div_den = slices;
         end
         2'd2: begin
            div_num = ({33'd0, wcol_ff} << 32) + {34'd0, slices[7:1]};
            div_den = slices;
         end
         default: begin
            div_num = ({33'd0, wring_ff} << 31) + {34'd0, last_ring[7:1]};
            div_den = last_ring;
         end
      endcase
   end

   always_comb begin
      case (row_ff)
         2'd0:    row_word = row_x_ff;
         2'd1:    row_word = row_y_ff;
         default: row_word = row_z_ff;
      endcase
      coef = row_word[47 - 12 * term_ff -: 12];
      case (term_ff)
         2'd0:    lsel = lx_ff;
         2'd1:    lsel = ly_ff;
         default: lsel = lz_ff;
      endcase
   end

   always_comb begin
      if (state_ff == ST_SPH) begin
         case (idx_ff)
            2'd0: begin
               mul_a = usvg_pkg::MUL_A_W'(se_ff);
               mul_b = {10'd0, radius_ff};
            end
            2'd1: begin
               mul_a = usvg_pkg::MUL_A_W'(ce_ff);
               mul_b = {10'd0, radius_ff};
            end
            2'd2: begin
               mul_a = usvg_pkg::MUL_A_W'(ca_ff);
               mul_b = ringr_ff;
            end
            default: begin
               mul_a = usvg_pkg::MUL_A_W'(sa_ff);
               mul_b = ringr_ff;
            end
         endcase
      end else begin
         mul_a = usvg_pkg::MUL_A_W'(lsel);
         mul_b = usvg_pkg::MUL_B_W'(coef);
      end
   end

   assign div_start = (state_ff == ST_DIV);
   assign cor_start = (state_ff == ST_COR);
   assign mul_start = (state_ff == ST_SPH) || (state_ff == ST_MAT);

   assign mul_pr = (idx_ff[1] ? (mul_p + (62'sd1 <<< 29)) : (mul_p + (62'sd1 <<< 21)));

   assign rnd     = acc_ff + (48'sd1 <<< (SH - 1));
   assign shifted = rnd >>> SH;
   assign sat     = (shifted > POS_MAX) ? POS_MAX[usvg_pkg::POS_W-1:0] :
                    (shifted < POS_MIN) ? POS_MIN[usvg_pkg::POS_W-1:0] :
                    shifted[usvg_pkg::POS_W-1:0];

   usvg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   usvg_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cor_start),
      .angle   (idx_ff[0] ? az_ff : el_ff),
      .done    (cor_done),
      .cos_out (cor_cos),
      .sin_out (cor_sin)
   );

   usvg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_SETUP;
         ST_SETUP: state_in = (ring_ff == 8'd0 || ring_ff >= last_ring) ? ST_MAT : ST_DIV;
         ST_DIV:   state_in = ST_DIVW;
         ST_DIVW:  if (div_done) state_in = (idx_ff == 2'd3) ? ST_COR : ST_DIV;
         ST_COR:   state_in = ST_CORW;
         ST_CORW:  if (cor_done) state_in = idx_ff[0] ? ST_SPH : ST_COR;
         ST_SPH:   state_in = ST_SPHW;
         ST_SPHW:  if (mul_done) state_in = (idx_ff == 2'd3) ? ST_MAT : ST_SPH;
         ST_MAT:   state_in = ST_MATW;
         ST_MATW:  if (mul_done) state_in = (term_ff == 2'd2) ? ST_ROUND : ST_MAT;
         ST_ROUND: state_in = (row_ff == 2'd2) ? ST_DONE : ST_MAT;
         ST_DONE: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         stack_count_ff <= 9'd8;
         slice_count_ff <= 8'd8;
         radius_ff      <= 16'd256;
         row_x_ff       <= 48'h100000000000;
         row_y_ff       <= 48'h000100000000;
         row_z_ff       <= 48'h000000100000;
         ring_ff        <= '0;
         col_ff         <= '0;
         vtx_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               usvg_pkg::CSR_STACK_COUNT:  stack_count_ff <= csr_write_data[8:0];
               usvg_pkg::CSR_SLICE_COUNT:  slice_count_ff <= csr_write_data[7:0];
               usvg_pkg::CSR_RADIUS:       radius_ff      <= csr_write_data[15:0];
               usvg_pkg::CSR_MATRIX_ROW_X: row_x_ff       <= csr_write_data;
               usvg_pkg::CSR_MATRIX_ROW_Y: row_y_ff       <= csr_write_data;
               usvg_pkg::CSR_MATRIX_ROW_Z: row_z_ff       <= csr_write_data;
               default: ;
            endcase
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_restart) begin
                  ring_ff <= '0;
                  col_ff  <= '0;
                  vtx_ff  <= '0;
               end
            end
            ST_SETUP: begin
               wring_ff <= ring_ff;
               wcol_ff  <= col_eff;
               wvtx_ff  <= vtx_ff;
               idx_ff   <= '0;
               row_ff   <= '0;
               term_ff  <= '0;
               lx_ff    <= '0;
               lz_ff    <= '0;
               if (ring_ff == 8'd0) begin
                  ly_ff    <= {2'b00, radius_ff, 8'd0};
                  tu_ff    <= '0;
                  tv_ff    <= '0;
                  wlast_ff <= 1'b0;
                  ring_ff  <= 8'd1;
                  col_ff   <= '0;
                  vtx_ff   <= 16'(vtx_ff + 1'b1);
               end else if (ring_ff >= last_ring) begin
                  ly_ff    <= -{2'b00, radius_ff, 8'd0};
                  tu_ff    <= 16'd32768;
                  tv_ff    <= 16'd32768;
                  wlast_ff <= 1'b1;
                  ring_ff  <= '0;
                  col_ff   <= '0;
                  vtx_ff   <= '0;
               end else begin
                  wlast_ff <= 1'b0;
                  if (col_eff >= slices) begin
                     ring_ff <= 8'(ring_ff + 1'b1);
                     col_ff  <= '0;
                  end else begin
                     col_ff <= 8'(col_eff + 1'b1);
                  end
                  vtx_ff <= 16'(vtx_ff + 1'b1);
               end
            end
            ST_DIVW: begin
               if (div_done) begin
                  case (idx_ff)
                     2'd0:    tv_ff <= div_quo[15:0];
                     2'd1:    tu_ff <= div_quo[15:0];
                     2'd2:    az_ff <= div_quo[31:0];
                     default: el_ff <= 32'(32'h4000_0000 - div_quo[31:0]);
                  endcase
                  idx_ff <= 2'(idx_ff + 1'b1);
               end
            end
            ST_CORW: begin
               if (cor_done) begin
                  if (idx_ff[0]) begin
                     ca_ff  <= cor_cos;
                     sa_ff  <= cor_sin;
                     idx_ff <= '0;
                  end else begin
                     ce_ff  <= cor_cos;
                     se_ff  <= cor_sin;
                     idx_ff <= 2'd1;
                  end
               end
            end
            ST_SPHW: begin
               if (mul_done) begin
                  case (idx_ff)
                     2'd0:    ly_ff    <= mul_pr[47:22];
                     2'd1:    ringr_ff <= mul_pr[47:22];
                     2'd2:    lx_ff    <= mul_pr[55:30];
                     default: lz_ff    <= mul_pr[55:30];
                  endcase
                  idx_ff <= 2'(idx_ff + 1'b1);
               end
            end
            ST_MATW: begin
               if (mul_done) begin
                  if (term_ff == 2'd0) begin
                     acc_ff <= (AW'(signed'(row_word[11:0])) <<< 16) + AW'(mul_p);
                  end else begin
                     acc_ff <= acc_ff + AW'(mul_p);
                  end
                  if (term_ff != 2'd2) begin
                     term_ff <= 2'(term_ff + 1'b1);
                  end
               end
            end
            ST_ROUND: begin
               pos_ff[row_ff] <= sat;
               term_ff        <= '0;
               row_ff         <= 2'(row_ff + 1'b1);
            end
            ST_DONE: begin
               if (out_free) begin
                  rsp_pos_x_ff        <= pos_ff[0];
                  rsp_pos_y_ff        <= pos_ff[1];
                  rsp_pos_z_ff        <= pos_ff[2];
                  rsp_tex_u_ff        <= tu_ff;
                  rsp_tex_v_ff        <= tv_ff;
                  rsp_vertex_index_ff <= wvtx_ff;
                  rsp_last_vertex_ff  <= wlast_ff;
               end
            end
            default: ;
         endcase
      end
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pos_x        = rsp_pos_x_ff;
   assign rsp_pos_y        = rsp_pos_y_ff;
   assign rsp_pos_z        = rsp_pos_z_ff;
   assign rsp_tex_u        = rsp_tex_u_ff;
   assign rsp_tex_v        = rsp_tex_v_ff;
   assign rsp_vertex_index = rsp_vertex_index_ff;
   assign rsp_last_vertex  = rsp_last_vertex_ff;
endmodule
`default_nettype wire
